// ----- rtl/fcvt_pkg.sv -----
`timescale 1ns / 1ps

package fcvt_pkg;

    typedef enum logic [2:0] {
        CMD_F32_TO_F16  = 3'd0,
        CMD_F16_TO_F32  = 3'd1,
        CMD_F32_TO_BF16 = 3'd2,
        CMD_BF16_TO_F32 = 3'd3,
        CMD_F32_VIA_F16 = 3'd4,
        CMD_F32_VIA_BF  = 3'd5
    } fcvt_cmd_t;

    localparam logic [14:0] HALF_QNAN     = 15'h7E00;
    localparam logic [14:0] HALF_INF      = 15'h7C00;
    localparam logic [31:0] BF_ROUND_BIAS = 32'h0000_7FFF;
    localparam logic [7:0]  F32_EXP_MAX   = 8'hFF;
    localparam logic [7:0]  HALF_OVF_EXP  = 8'd143;  // biased fp32 exponent giving fp16 exp 31
    localparam logic [7:0]  HALF_MIN_EXP  = 8'd102;  // below this the value flushes to zero
    localparam logic [7:0]  HALF_BIAS_ADJ = 8'd112;
    localparam logic [7:0]  HALF_SUB_SH   = 8'd126;
    localparam logic [4:0]  HALF_NORM_SH  = 5'd13;
    localparam logic [7:0]  F32_SUB_BASE  = 8'd103;

    // first stage view of an fp32 operand heading for fp16
    typedef struct packed {
        logic        sign;
        logic        is_fix;
        logic [14:0] fix_val;
        logic [23:0] m24;
        logic [4:0]  sh;
        logic [4:0]  he;
        logic [15:0] bf16;
    } fcvt_pre_t;

endpackage

// ----- rtl/fp32_fp16_bf16_converter_core.sv -----
`timescale 1ns / 1ps
// channel   | ports                             | contents
// input     | s_tvalid s_tready s_tdata s_tuser | tdata[31:0] operand, tuser[2:0] cmd
// result    | m_tvalid m_tready m_tdata         | tdata[31:0] converted
//
// one item per cycle while m_tready does not stall the output; each item passes
// the a and b stage registers and then the output register before m_tvalid rises
// stages: classify and bf16 add, fp16 round, widen and select into the output register
// aresetn (synchronous) empties all stages; payload registers are not reset
// a stall at m_tready holds each stage that is full; empty stages keep filling

module fp32_fp16_bf16_converter_core import fcvt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] converted
);

    logic        a_valid_reg;
    fcvt_cmd_t   a_cmd_reg;
    logic [31:0] a_op_reg;
    fcvt_pre_t   a_pre_reg;
    fcvt_pre_t   a_pre_next;

    logic        b_valid_reg;
    fcvt_cmd_t   b_cmd_reg;
    logic [31:0] b_op_reg;
    logic [15:0] b_half_reg;
    logic [15:0] b_bf16_reg;
    logic [15:0] b_half_next;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [31:0] m_data_next;

    logic        out_en;
    logic        b_en;
    logic        a_en;
    logic [15:0] wide_src;
    logic [31:0] wide_res;

    assign out_en   = !m_valid_reg || m_tready;
    assign b_en     = !b_valid_reg || out_en;
    assign a_en     = !a_valid_reg || b_en;
    assign s_tready = a_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    fcvt_prep u_prep (
        .operand (s_tdata),
        .pre     (a_pre_next)
    );

    fcvt_round u_round (
        .pre  (a_pre_reg),
        .half (b_half_next)
    );

    assign wide_src = (b_cmd_reg == CMD_F16_TO_F32) ? b_op_reg[15:0] : b_half_reg;

    fcvt_widen u_widen (
        .half   (wide_src),
        .single (wide_res)
    );

    always_comb begin
        case (b_cmd_reg) inside
            CMD_F32_TO_F16:                  m_data_next = {16'b0, b_half_reg};
            CMD_F16_TO_F32, CMD_F32_VIA_F16: m_data_next = wide_res;
            CMD_F32_TO_BF16:                 m_data_next = {16'b0, b_bf16_reg};
            CMD_BF16_TO_F32:                 m_data_next = {b_op_reg[15:0], 16'b0};
            CMD_F32_VIA_BF:                  m_data_next = {b_bf16_reg, 16'b0};
            default:                         m_data_next = b_op_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (a_en)   a_valid_reg <= s_tvalid;
            if (b_en)   b_valid_reg <= a_valid_reg;
            if (out_en) m_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_cmd_reg <= fcvt_cmd_t'(s_tuser);
            a_op_reg  <= s_tdata;
            a_pre_reg <= a_pre_next;
        end
        if (b_en) begin
            b_cmd_reg  <= a_cmd_reg;
            b_op_reg   <= a_op_reg;
            b_half_reg <= b_half_next;
            b_bf16_reg <= a_pre_reg.bf16;
        end
        if (out_en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// ----- rtl/fcvt_prep.sv -----
`timescale 1ns / 1ps

module fcvt_prep import fcvt_pkg::*; (
    input  logic [31:0] operand,
    output fcvt_pre_t   pre
);

    logic        sign;
    logic [7:0]  ef;
    logic [22:0] mant;
    logic [31:0] bf_sum;

    assign sign = operand[31];
    assign ef   = operand[30:23];
    assign mant = operand[22:0];

    // bf16 rounding wraps modulo 2^32, no nan check
    assign bf_sum = operand + BF_ROUND_BIAS + {31'b0, operand[16]};

    always_comb begin
        pre.sign    = sign;
        pre.is_fix  = 1'b0;
        pre.fix_val = '0;
        pre.m24     = {1'b0, mant};
        pre.sh      = HALF_NORM_SH;
        pre.he      = '0;
        pre.bf16    = bf_sum[31:16];
        if (ef == F32_EXP_MAX) begin
            pre.is_fix  = 1'b1;
            pre.fix_val = (mant != '0) ? HALF_QNAN : HALF_INF;
        end else if (ef >= HALF_OVF_EXP) begin
            pre.is_fix  = 1'b1;
            pre.fix_val = HALF_INF;
        end else if (ef < HALF_MIN_EXP) begin
            pre.is_fix  = 1'b1;
            pre.fix_val = '0;
        end else if (ef <= HALF_BIAS_ADJ) begin
            // fp16 subnormal: hidden bit joins, shift of 14 to 24
            pre.m24 = {1'b1, mant};
            pre.sh  = 5'(HALF_SUB_SH - ef);
        end else begin
            pre.he = 5'(ef - HALF_BIAS_ADJ);
        end
    end

endmodule

// ----- rtl/fcvt_round.sv -----
`timescale 1ns / 1ps

module fcvt_round import fcvt_pkg::*; (
    input  fcvt_pre_t   pre,
    output logic [15:0] half
);

    logic [23:0] hm;
    logic [23:0] mask;
    logic [23:0] rem;
    logic [23:0] halfway;
    logic        up;
    logic [14:0] mag;

    assign hm      = pre.m24 >> pre.sh;
    assign mask    = (24'h1 << pre.sh) - 24'h1;
    assign rem     = pre.m24 & mask;
    assign halfway = 24'h1 << (pre.sh - 5'd1);
    assign up      = (rem > halfway) || ((rem == halfway) && hm[0]);

    // a mantissa carry runs into the exponent field, up to infinity
    assign mag  = {pre.he, 10'b0} + {5'b0, hm[9:0]} + {14'b0, up};
    assign half = pre.is_fix ? {pre.sign, pre.fix_val} : {pre.sign, mag};

endmodule

// ----- rtl/fcvt_widen.sv -----
`timescale 1ns / 1ps

module fcvt_widen import fcvt_pkg::*; (
    input  logic [15:0] half,
    output logic [31:0] single
);

    logic        sign;
    logic [4:0]  ef;
    logic [9:0]  mant;
    logic [3:0]  msb;
    logic [3:0]  sft;
    logic [10:0] norm;
    logic [7:0]  e8;

    assign sign = half[15];
    assign ef   = half[14:10];
    assign mant = half[9:0];

    always_comb begin
        msb = '0;
        for (int i = 0; i < 10; i++) begin
            if (mant[i]) msb = 4'(i);
        end
    end

    assign sft  = 4'd10 - msb;
    assign norm = {1'b0, mant} << sft;
    assign e8   = F32_SUB_BASE + {4'b0, msb};

    always_comb begin
        if (ef == '0) begin
            if (mant == '0) single = {sign, 31'b0};
            else            single = {sign, e8, norm[9:0], 13'b0};
        end else if (ef == 5'h1F) begin
            single = {sign, F32_EXP_MAX, mant, 13'b0};
        end else begin
            single = {sign, 8'({3'b0, ef} + HALF_BIAS_ADJ), mant, 13'b0};
        end
    end

endmodule

// ----- rtl/fcvt_checker.sv -----
`timescale 1ns / 1ps

module fcvt_props import fcvt_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a free output lets the whole pipeline move
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input blocked while output drains");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready) |=> m_tvalid)
        else $error("result missing three cycles after transfer");

    a_bf16_widen: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && m_tready && (s_tuser == CMD_BF16_TO_F32)
            ##1 m_tready ##1 m_tready)
        |=> m_tdata == {$past(s_tdata[15:0], 3), 16'b0})
        else $error("bf16 widening result wrong");

endmodule

bind fp32_fp16_bf16_converter_core fcvt_props u_fcvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
